@@ rtl/tlpt_pkg.sv @@
// Shared types, constants and descriptor coding for the two-level page table engine.
`timescale 1ns / 1ps
`default_nettype none
package tlpt_pkg;

  localparam int TOP_ENTRIES  = 4096;
  localparam int TOP_AW       = 12;
  localparam int LEAF_ENTRIES = 256;
  localparam int LEAF_AW      = 8;
  localparam int OCC_W        = $clog2(LEAF_ENTRIES + 1);
  localparam int PADDR_W      = 2;

  localparam logic [31:0] FRAME_MASK = 32'hFFFF_F000;
  localparam logic [31:0] D_SMALL    = 32'h0000_0002;
  localparam logic [31:0] D_XN       = 32'h0000_0001;
  localparam logic [31:0] D_B        = 32'h0000_0004;
  localparam logic [31:0] D_C        = 32'h0000_0008;
  localparam logic [31:0] D_AP0      = 32'h0000_0010;
  localparam logic [31:0] D_AP1      = 32'h0000_0020;
  localparam logic [31:0] D_AP2      = 32'h0000_0200;
  localparam logic [31:0] D_NG       = 32'h0000_0800;

  typedef enum logic [1:0] {
    REQ_MAP     = 2'd0,
    REQ_UNMAP   = 2'd1,
    REQ_PROTECT = 2'd2,
    REQ_QUERY   = 2'd3
  } req_type_t;

  typedef enum logic [1:0] {
    STS_OK      = 2'd0,
    STS_INVALID = 2'd1,
    STS_NOT_MAP = 2'd2,
    STS_NO_FREE = 2'd3
  } status_t;

  typedef enum logic [1:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_LOOK,
    ST_EXEC
  } state_t;

  typedef struct packed {
    logic [1:0]  req_type;
    logic [31:0] virt_addr;
    logic [31:0] frame_addr;
    logic [4:0]  req_flags;
  } req_t;

  typedef struct packed {
    logic [1:0]  status;
    logic [31:0] found_paddr;
    logic [5:0]  found_flags;
    logic [31:0] found_descriptor;
  } rsp_t;

  typedef struct packed {
    logic fill;
    logic pop;
    logic push;
  } pool_ctl_t;

  function automatic logic [31:0] encode_desc(input logic [31:0] frame,
                                              input logic [4:0]  f);
    logic [31:0] d;
    d = (frame & FRAME_MASK) | D_SMALL;
    if (!f[4]) d = d | D_C | D_B;
    if (f[1]) begin
      d = f[0] ? (d | D_AP1 | D_AP0) : (d | D_AP2 | D_AP1 | D_AP0);
    end else begin
      d = f[0] ? (d | D_AP0) : (d | D_AP2 | D_AP0);
    end
    if (!f[2]) d = d | D_XN;
    if (!f[3]) d = d | D_NG;
    return d;
  endfunction

  function automatic logic [5:0] decode_desc(input logic [31:0] d);
    logic [5:0] r;
    logic [2:0] ap;
    r  = 6'd1;
    ap = {d[9], d[5], d[4]};
    if (ap == 3'd1) r = r | 6'd2;
    else if (ap == 3'd3) r = r | 6'd6;
    else if (ap == 3'd7) r = r | 6'd4;
    if (!d[0]) r = r | 6'd8;
    if (!d[11]) r = r | 6'd16;
    if (d[3:2] == 2'b00) r = r | 6'd32;
    return r;
  endfunction

endpackage
`default_nettype wire

@@ rtl/tlpt_ram.sv @@
// Generic single-write, single-read synchronous RAM with registered read data.
`timescale 1ns / 1ps
`default_nettype none
module tlpt_ram #(
  parameter int WIDTH  = 32,
  parameter int DEPTH  = 256,
  parameter int ADDR_W = 8
) (
  input  wire logic              clk,
  input  wire logic              we,
  input  wire logic [ADDR_W-1:0] waddr,
  input  wire logic [WIDTH-1:0]  wdata,
  input  wire logic [ADDR_W-1:0] raddr,
  output logic      [WIDTH-1:0]  rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule
`default_nettype wire

@@ rtl/tlpt_free_pool.sv @@
// Free second-level table queue: circular list of table numbers in a RAM.
`timescale 1ns / 1ps
`default_nettype none
module tlpt_free_pool #(
  parameter int   LEAF_TABLES = 64,
  localparam int  TW          = (LEAF_TABLES > 1) ? $clog2(LEAF_TABLES) : 1
) (
  input  wire logic                  clk,
  input  wire logic                  rst_n,
  input  wire tlpt_pkg::pool_ctl_t   ctl,
  input  wire logic [TW-1:0]         fill_id,
  input  wire logic [TW-1:0]         push_id,
  output logic      [TW-1:0]         head_id,
  output logic                       empty
);
  import tlpt_pkg::*;

  localparam int CNT_W = $clog2(LEAF_TABLES + 1);
  localparam logic [TW-1:0] LAST = TW'(LEAF_TABLES - 1);

  logic [TW-1:0]    head_r, head_nxt;
  logic [TW-1:0]    tail_r, tail_nxt;
  logic [CNT_W-1:0] cnt_r, cnt_nxt;
  logic             we;
  logic [TW-1:0]    waddr;
  logic [TW-1:0]    wdata;

  always_comb begin
    head_nxt = head_r;
    tail_nxt = tail_r;
    cnt_nxt  = cnt_r;
    if (ctl.pop) begin
      head_nxt = (head_r == LAST) ? '0 : head_r + TW'(1);
      cnt_nxt  = cnt_r - CNT_W'(1);
    end
    if (ctl.push) begin
      tail_nxt = (tail_r == LAST) ? '0 : tail_r + TW'(1);
      cnt_nxt  = cnt_r + CNT_W'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      head_r <= '0;
      tail_r <= '0;
      cnt_r  <= CNT_W'(LEAF_TABLES);
    end else begin
      head_r <= head_nxt;
      tail_r <= tail_nxt;
      cnt_r  <= cnt_nxt;
    end
  end

  assign we    = ctl.fill | ctl.push;
  assign waddr = ctl.fill ? fill_id : tail_r;
  assign wdata = ctl.fill ? fill_id : push_id;
  assign empty = (cnt_r == '0);

  tlpt_ram #(
    .WIDTH  (TW),
    .DEPTH  (LEAF_TABLES),
    .ADDR_W (TW)
  ) u_list_ram (
    .clk   (clk),
    .we    (we),
    .waddr (waddr),
    .wdata (wdata),
    .raddr (head_r),
    .rdata (head_id)
  );

endmodule
`default_nettype wire

@@ rtl/two_level_page_table_engine.sv @@
// Top level of the two-level page table engine: request sequencer, table memories, APB register.
`timescale 1ns / 1ps
`default_nettype none
// The first-level slot RAM is read at the accepting edge, then the descriptor
// and count RAMs, then the write-back loads the result register. The next
// item is accepted only once the block is back in idle after that write-back,
// so a new item is not taken while the last one is in flight. The pace is set
// by the dependent reads of the first-level slot RAM and then the descriptor
// RAM, each with registered read data. A result waits in an output register
// while the next item is accepted; that item holds in its write-back stage
// until the waiting result is taken. After reset a clearing pass zeroes the
// slot, descriptor and count RAMs and fills the free-table queue; no item is
// accepted during it, while register writes are taken as usual.
module two_level_page_table_engine #(
  parameter int LEAF_TABLES = 64
) (
  input  wire logic                        clk,
  input  wire logic                        rst_n,
  input  wire logic                        in_valid,
  output logic                             in_ready,
  input  wire tlpt_pkg::req_t              in_data,
  output logic                             out_valid,
  input  wire logic                        out_ready,
  output tlpt_pkg::rsp_t                   out_data,
  input  wire logic                        psel,
  input  wire logic                        penable,
  input  wire logic                        pwrite,
  input  wire logic [tlpt_pkg::PADDR_W-1:0] paddr,
  input  wire logic [31:0]                 pwdata,
  output logic      [31:0]                 prdata,
  output logic                             pready
);
  import tlpt_pkg::*;

  localparam int TW     = (LEAF_TABLES > 1) ? $clog2(LEAF_TABLES) : 1;
  localparam int TOPW   = $clog2(LEAF_TABLES + 1);
  localparam int LAW    = TW + LEAF_AW;
  localparam int LEAF_N = LEAF_TABLES * LEAF_ENTRIES;
  localparam int CLR_N  = (LEAF_N > TOP_ENTRIES) ? LEAF_N : TOP_ENTRIES;
  localparam int CW     = $clog2(CLR_N + 1);

  state_t state_r, state_nxt;
  logic [CW-1:0] clr_r, clr_nxt;
  req_t          req_r, req_nxt;
  logic [TW-1:0] t_r, t_nxt;
  logic          have_r, have_nxt;
  logic          out_valid_r, out_valid_nxt;
  rsp_t          out_data_r, out_data_nxt;
  logic          space_present_r;

  logic            top_we;
  logic [TOP_AW-1:0] top_waddr;
  logic [TOPW-1:0] top_wdata;
  logic [TOPW-1:0] top_rdata;
  logic            leaf_we;
  logic [LAW-1:0]  leaf_waddr;
  logic [31:0]     leaf_wdata;
  logic [LAW-1:0]  leaf_raddr;
  logic [31:0]     leaf_rdata;
  logic            occ_we;
  logic [TW-1:0]   occ_waddr;
  logic [OCC_W-1:0] occ_wdata;
  logic [OCC_W-1:0] occ_rdata;
  pool_ctl_t       pool_ctl;
  logic [TW-1:0]   head_id;
  logic            pool_empty;

  logic             look_have;
  logic [TW-1:0]    look_t;
  logic [TW-1:0]    rd_t;
  logic             commit;
  logic             mapped;
  logic [OCC_W-1:0] occ_cur;
  logic [OCC_W-1:0] occ_dec;

  // configuration register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      space_present_r <= 1'b0;
    end else if (psel && penable && pwrite) begin
      space_present_r <= pwdata[0];
    end
  end

  assign pready = 1'b1;
  assign prdata = 32'(space_present_r);

  // slot lookup; hold the table number while the write-back stage waits
  assign look_have  = (top_rdata != '0);
  assign look_t     = look_have ? TW'(top_rdata - TOPW'(1)) : head_id;
  assign rd_t       = (state_r == ST_LOOK) ? look_t : t_r;
  assign leaf_raddr = {rd_t, req_r.virt_addr[19:12]};

  assign in_ready  = (state_r == ST_IDLE);
  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;
  assign commit    = (state_r == ST_EXEC) && (!out_valid_r || out_ready);
  assign mapped    = have_r && leaf_rdata[1];
  assign occ_cur   = have_r ? occ_rdata : '0;
  assign occ_dec   = (occ_cur != '0) ? occ_cur - OCC_W'(1) : '0;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_CLEAR;
      clr_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      clr_r       <= clr_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    req_r      <= req_nxt;
    t_r        <= t_nxt;
    have_r     <= have_nxt;
    out_data_r <= out_data_nxt;
  end

  always_comb begin
    state_nxt     = state_r;
    clr_nxt       = clr_r;
    req_nxt       = req_r;
    t_nxt         = t_r;
    have_nxt      = have_r;
    out_valid_nxt = out_valid_r;
    out_data_nxt  = out_data_r;
    top_we        = 1'b0;
    top_waddr     = req_r.virt_addr[31:20];
    top_wdata     = '0;
    leaf_we       = 1'b0;
    leaf_waddr    = {t_r, req_r.virt_addr[19:12]};
    leaf_wdata    = '0;
    occ_we        = 1'b0;
    occ_waddr     = t_r;
    occ_wdata     = '0;
    pool_ctl      = '0;

    if (out_valid_r && out_ready) begin
      out_valid_nxt = 1'b0;
    end

    unique case (state_r)
      ST_CLEAR: begin
        top_we     = (clr_r < CW'(TOP_ENTRIES));
        top_waddr  = clr_r[TOP_AW-1:0];
        leaf_we    = (clr_r < CW'(LEAF_N));
        leaf_waddr = clr_r[LAW-1:0];
        occ_we     = (clr_r < CW'(LEAF_TABLES));
        occ_waddr  = clr_r[TW-1:0];
        pool_ctl.fill = (clr_r < CW'(LEAF_TABLES));
        clr_nxt    = clr_r + CW'(1);
        if (clr_r == CW'(CLR_N - 1)) begin
          state_nxt = ST_IDLE;
        end
      end
      ST_IDLE: begin
        if (in_valid) begin
          req_nxt   = in_data;
          state_nxt = ST_LOOK;
        end
      end
      ST_LOOK: begin
        have_nxt  = look_have;
        t_nxt     = look_t;
        state_nxt = ST_EXEC;
      end
      ST_EXEC: begin
        if (commit) begin
          out_valid_nxt = 1'b1;
          out_data_nxt  = '0;
          state_nxt     = ST_IDLE;
          if (!space_present_r) begin
            out_data_nxt.status = STS_INVALID;
          end else if (req_r.req_type == REQ_MAP) begin
            if (req_r.frame_addr == '0) begin
              out_data_nxt.status = STS_INVALID;
            end else if (!have_r && pool_empty) begin
              out_data_nxt.status = STS_NO_FREE;
            end else begin
              out_data_nxt.status = STS_OK;
              leaf_we    = 1'b1;
              leaf_wdata = encode_desc(req_r.frame_addr, req_r.req_flags);
              occ_we     = 1'b1;
              occ_wdata  = occ_cur + OCC_W'(leaf_rdata[1:0] == 2'b00);
              if (!have_r) begin
                top_we       = 1'b1;
                top_wdata    = TOPW'(t_r) + TOPW'(1);
                pool_ctl.pop = 1'b1;
              end
            end
          end else if (!mapped) begin
            out_data_nxt.status = STS_NOT_MAP;
          end else begin
            out_data_nxt.status = STS_OK;
            unique case (req_r.req_type)
              REQ_UNMAP: begin
                out_data_nxt.found_paddr = leaf_rdata & FRAME_MASK;
                leaf_we   = 1'b1;
                occ_we    = 1'b1;
                occ_wdata = occ_dec;
                if (occ_dec == '0) begin
                  top_we        = 1'b1;
                  pool_ctl.push = 1'b1;
                end
              end
              REQ_PROTECT: begin
                leaf_we    = 1'b1;
                leaf_wdata = encode_desc(leaf_rdata, req_r.req_flags);
              end
              REQ_QUERY: begin
                out_data_nxt.found_descriptor = leaf_rdata;
                out_data_nxt.found_paddr      = leaf_rdata & FRAME_MASK;
                out_data_nxt.found_flags      = decode_desc(leaf_rdata & 32'h0000_0FFF);
              end
              default: begin
                out_data_nxt.status = STS_OK;
              end
            endcase
          end
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  tlpt_ram #(
    .WIDTH  (TOPW),
    .DEPTH  (TOP_ENTRIES),
    .ADDR_W (TOP_AW)
  ) u_top_ram (
    .clk   (clk),
    .we    (top_we),
    .waddr (top_waddr),
    .wdata (top_wdata),
    .raddr (in_data.virt_addr[31:20]),
    .rdata (top_rdata)
  );

  tlpt_ram #(
    .WIDTH  (32),
    .DEPTH  (LEAF_N),
    .ADDR_W (LAW)
  ) u_leaf_ram (
    .clk   (clk),
    .we    (leaf_we),
    .waddr (leaf_waddr),
    .wdata (leaf_wdata),
    .raddr (leaf_raddr),
    .rdata (leaf_rdata)
  );

  tlpt_ram #(
    .WIDTH  (OCC_W),
    .DEPTH  (LEAF_TABLES),
    .ADDR_W (TW)
  ) u_occ_ram (
    .clk   (clk),
    .we    (occ_we),
    .waddr (occ_waddr),
    .wdata (occ_wdata),
    .raddr (rd_t),
    .rdata (occ_rdata)
  );

  tlpt_free_pool #(
    .LEAF_TABLES (LEAF_TABLES)
  ) u_free_pool (
    .clk     (clk),
    .rst_n   (rst_n),
    .ctl     (pool_ctl),
    .fill_id (clr_r[TW-1:0]),
    .push_id (t_r),
    .head_id (head_id),
    .empty   (pool_empty)
  );

  logic unused_paddr;
  assign unused_paddr = ^paddr;

endmodule
`default_nettype wire

@@ verif/two_level_page_table_engine_test.sv @@
// Self-checking testbench for the two-level page table engine: directed table, random traffic, pool exhaustion.
`timescale 1ns / 1ps
module two_level_page_table_engine_test;
  import tlpt_pkg::*;

  localparam int POOL = 64;
  localparam logic [PADDR_W-1:0] REG_SPACE = '0;
  localparam int NPLAN = 27;
  localparam int OFF_ROWS = 2;

  typedef struct packed {
    logic fixed;
    req_t rq;
    rsp_t want;
  } row_t;

  localparam rsp_t R_OK    = '{STS_OK, 32'h0, 6'h0, 32'h0};
  localparam rsp_t R_INV   = '{STS_INVALID, 32'h0, 6'h0, 32'h0};
  localparam rsp_t R_NOMAP = '{STS_NOT_MAP, 32'h0, 6'h0, 32'h0};
  localparam rsp_t R_CALC  = '0;

  localparam row_t PLAN [NPLAN] = '{
    '{1'b1, '{REQ_MAP,     32'h0000_0000, 32'h0000_1000, 5'h00}, R_INV},
    '{1'b1, '{REQ_QUERY,   32'hFFFF_FFFF, 32'h0000_0000, 5'h1F}, R_INV},
    '{1'b1, '{REQ_QUERY,   32'h0000_0000, 32'h0000_0000, 5'h00}, R_NOMAP},
    '{1'b1, '{REQ_UNMAP,   32'h1234_5678, 32'h0000_0000, 5'h00}, R_NOMAP},
    '{1'b1, '{REQ_PROTECT, 32'hFFFF_F000, 32'h0000_0000, 5'h1F}, R_NOMAP},
    '{1'b1, '{REQ_MAP,     32'h0000_0000, 32'h0000_0000, 5'h1F}, R_INV},
    '{1'b1, '{REQ_MAP,     32'h0000_0000, 32'h0000_0FFF, 5'h00}, R_OK},
    '{1'b0, '{REQ_QUERY,   32'h0000_0000, 32'h0000_0000, 5'h00}, R_CALC},
    '{1'b1, '{REQ_MAP,     32'hFFFF_FFFF, 32'hFFFF_FFFF, 5'h1F}, R_OK},
    '{1'b0, '{REQ_QUERY,   32'hFFFF_F123, 32'h0000_0000, 5'h00}, R_CALC},
    '{1'b1, '{REQ_PROTECT, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 5'h00}, R_OK},
    '{1'b0, '{REQ_QUERY,   32'hFFFF_F000, 32'h0000_0000, 5'h00}, R_CALC},
    '{1'b1, '{REQ_MAP,     32'h0000_1000, 32'h8000_0000, 5'h03}, R_OK},
    '{1'b0, '{REQ_QUERY,   32'h0000_1000, 32'h0000_0000, 5'h00}, R_CALC},
    '{1'b1, '{REQ_MAP,     32'h0000_1000, 32'h4000_0ABC, 5'h02}, R_OK},
    '{1'b0, '{REQ_QUERY,   32'h0000_1FFF, 32'h0000_0000, 5'h00}, R_CALC},
    '{1'b1, '{REQ_MAP,     32'h0000_2000, 32'h1234_5000, 5'h01}, R_OK},
    '{1'b0, '{REQ_QUERY,   32'h0000_2000, 32'h0000_0000, 5'h00}, R_CALC},
    '{1'b1, '{REQ_MAP,     32'h0000_3000, 32'hABCD_E000, 5'h1C}, R_OK},
    '{1'b0, '{REQ_QUERY,   32'h0000_3000, 32'h0000_0000, 5'h00}, R_CALC},
    '{1'b0, '{REQ_UNMAP,   32'h0000_1000, 32'h0000_0000, 5'h00}, R_CALC},
    '{1'b1, '{REQ_UNMAP,   32'h0000_1000, 32'h0000_0000, 5'h00}, R_NOMAP},
    '{1'b0, '{REQ_UNMAP,   32'h0000_0000, 32'h0000_0000, 5'h00}, R_CALC},
    '{1'b0, '{REQ_UNMAP,   32'h0000_2000, 32'h0000_0000, 5'h00}, R_CALC},
    '{1'b0, '{REQ_UNMAP,   32'h0000_3000, 32'h0000_0000, 5'h00}, R_CALC},
    '{1'b1, '{REQ_QUERY,   32'h0000_3000, 32'h0000_0000, 5'h00}, R_NOMAP},
    '{1'b0, '{REQ_UNMAP,   32'hFFFF_FFFF, 32'h0000_0000, 5'h00}, R_CALC}
  };

  logic               clk;
  logic               rst_n = 1'b0;
  logic               in_valid = 1'b0;
  logic               in_ready;
  req_t               in_data = '0;
  logic               out_valid;
  logic               out_ready = 1'b0;
  rsp_t               out_data;
  logic               psel = 1'b0;
  logic               penable = 1'b0;
  logic               pwrite = 1'b0;
  logic [PADDR_W-1:0] paddr = '0;
  logic [31:0]        pwdata = '0;
  logic [31:0]        prdata;
  logic               pready;

  two_level_page_table_engine #(.LEAF_TABLES(POOL)) dut (
    .clk(clk), .rst_n(rst_n),
    .in_valid(in_valid), .in_ready(in_ready), .in_data(in_data),
    .out_valid(out_valid), .out_ready(out_ready), .out_data(out_data),
    .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
    .pwdata(pwdata), .prdata(prdata), .pready(pready)
  );

  int unsigned slot_owner [TOP_ENTRIES];
  logic [31:0] leaf_pte [POOL*LEAF_ENTRIES];
  bit          table_busy [POOL];
  int          table_fill [POOL];
  bit          space_on;

  rsp_t        pending_rsp [$];
  int          mismatches;
  int          items_sent;
  int          results_seen;
  bit          calm_in;
  bit          calm_out;
  logic [11:0] ws_slot [8];
  logic [7:0]  ws_leaf [4];

  initial begin
    clk = 1'b0;
    forever #6 clk = ~clk;
  end

  initial begin
    #10_000_000;
    $display("simulation failed");
    $finish;
  end

  function automatic logic [31:0] pte_bits(input logic [31:0] frame, input logic [4:0] f);
    logic [31:0] d;
    d = {frame[31:12], 12'h000} | D_SMALL;
    if (!f[4]) d = d | D_C | D_B;
    case (f[1:0])
      2'b11: d = d | D_AP1 | D_AP0;
      2'b10: d = d | D_AP2 | D_AP1 | D_AP0;
      2'b01: d = d | D_AP0;
      default: d = d | D_AP2 | D_AP0;
    endcase
    if (!f[2]) d = d | D_XN;
    if (!f[3]) d = d | D_NG;
    return d;
  endfunction

  function automatic logic [5:0] perm_bits(input logic [31:0] d);
    logic [5:0] r;
    r = 6'b000001;
    case ({d[9], d[5], d[4]})
      3'b001: r[1] = 1'b1;
      3'b011: r[2:1] = 2'b11;
      3'b111: r[2] = 1'b1;
      default: ;
    endcase
    r[3] = !d[0];
    r[4] = !d[11];
    r[5] = (d[3:2] == 2'b00);
    return r;
  endfunction

  // apply one request to the shadow tables and return its result
  function automatic rsp_t walk_table(input req_t r);
    rsp_t        e;
    logic [11:0] s;
    logic [7:0]  lf;
    int          t;
    int          p;
    int          i;
    bit          hit;
    e = R_OK;
    s = r.virt_addr[31:20];
    lf = r.virt_addr[19:12];
    hit = slot_owner[s] != 0;
    t = hit ? int'(slot_owner[s]) - 1 : 0;
    p = t * LEAF_ENTRIES + lf;
    if (!space_on) begin
      e.status = STS_INVALID;
    end else if (r.req_type == REQ_MAP) begin
      if (r.frame_addr == 32'h0) begin
        e.status = STS_INVALID;
      end else begin
        if (!hit) begin
          i = 0;
          while (i < POOL && table_busy[i]) i++;
          if (i < POOL) begin
            t = i;
            table_busy[t] = 1'b1;
            table_fill[t] = 0;
            for (int j = 0; j < LEAF_ENTRIES; j++) leaf_pte[t*LEAF_ENTRIES + j] = '0;
            slot_owner[s] = t + 1;
            p = t * LEAF_ENTRIES + lf;
            hit = 1'b1;
          end
        end
        if (!hit) begin
          e.status = STS_NO_FREE;
        end else begin
          if (leaf_pte[p][1:0] == 2'b00) table_fill[t]++;
          leaf_pte[p] = pte_bits(r.frame_addr, r.req_flags);
        end
      end
    end else if (!hit || !leaf_pte[p][1]) begin
      e.status = STS_NOT_MAP;
    end else begin
      case (r.req_type)
        REQ_UNMAP: begin
          e.found_paddr = leaf_pte[p] & FRAME_MASK;
          leaf_pte[p] = '0;
          if (table_fill[t] > 0) table_fill[t]--;
          if (table_fill[t] == 0) begin
            table_busy[t] = 1'b0;
            slot_owner[s] = 0;
          end
        end
        REQ_PROTECT: leaf_pte[p] = pte_bits(leaf_pte[p], r.req_flags);
        default: begin
          e.found_descriptor = leaf_pte[p];
          e.found_paddr = leaf_pte[p] & FRAME_MASK;
          e.found_flags = perm_bits(leaf_pte[p]);
        end
      endcase
    end
    return e;
  endfunction

  function automatic int gap_len(input bit calm);
    int k;
    k = $urandom_range(0, 99);
    if (calm || k < 55) return 0;
    if (k < 93) return $urandom_range(1, 3);
    return $urandom_range(8, 40);
  endfunction

  task automatic put_item(input req_t r, input bit fixed, input rsp_t want);
    rsp_t e;
    int   n;
    n = gap_len(calm_in);
    if (n > 0) begin
      in_valid <= 1'b0;
      repeat (n) @(posedge clk);
    end
    in_valid <= 1'b1;
    in_data <= r;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    e = walk_table(r);
    pending_rsp.push_back(fixed ? want : e);
    items_sent++;
    if (items_sent % 64 == 0) calm_in = ($urandom_range(0, 3) == 0);
  endtask

  task automatic drain_results();
    in_valid <= 1'b0;
    while (pending_rsp.size() != 0) @(posedge clk);
  endtask

  task automatic write_space(input logic [31:0] v);
    psel <= 1'b1;
    penable <= 1'b0;
    pwrite <= 1'b1;
    paddr <= REG_SPACE;
    pwdata <= v;
    @(posedge clk);
    penable <= 1'b1;
    @(posedge clk);
    while (!pready) @(posedge clk);
    psel <= 1'b0;
    penable <= 1'b0;
    pwrite <= 1'b0;
    space_on = v[0];
  endtask

  task automatic pick_working_set();
    ws_slot[0] = 12'h000;
    ws_slot[1] = 12'hFFF;
    for (int i = 2; i < 8; i++) ws_slot[i] = 12'($urandom);
    ws_leaf[0] = 8'h00;
    ws_leaf[1] = 8'hFF;
    ws_leaf[2] = 8'($urandom);
    ws_leaf[3] = 8'($urandom);
  endtask

  function automatic req_t rand_req();
    req_t r;
    int   k;
    k = $urandom_range(0, 99);
    r.req_type = k < 35 ? REQ_MAP : k < 55 ? REQ_UNMAP : k < 70 ? REQ_PROTECT : REQ_QUERY;
    r.virt_addr = $urandom;
    if ($urandom_range(0, 15) != 0)
      r.virt_addr[31:12] = {ws_slot[$urandom_range(0, 7)], ws_leaf[$urandom_range(0, 3)]};
    k = $urandom_range(0, 49);
    r.frame_addr = k == 0 ? 32'h0 : k == 1 ? ($urandom & 32'hFFF) : $urandom;
    r.req_flags = 5'($urandom_range(0, 31));
    return r;
  endfunction

  task automatic report(input string field, input logic [31:0] want, input logic [31:0] got);
    $display("%0t: %s expected %0h got %0h", $time, field, want, got);
    mismatches++;
  endtask

  task automatic check_rsp(input rsp_t got);
    rsp_t e;
    if (pending_rsp.size() == 0) begin
      $display("%0t: result with none expected, got %h", $time, got);
      mismatches++;
      return;
    end
    e = pending_rsp.pop_front();
    if (got.status !== e.status) report("status", 32'(e.status), 32'(got.status));
    if (got.found_paddr !== e.found_paddr) report("found_paddr", e.found_paddr, got.found_paddr);
    if (got.found_flags !== e.found_flags)
      report("found_flags", 32'(e.found_flags), 32'(got.found_flags));
    if (got.found_descriptor !== e.found_descriptor)
      report("found_descriptor", e.found_descriptor, got.found_descriptor);
  endtask

  // result side: random back-pressure plus one long hold-off
  initial begin
    int  n;
    int  turns;
    bit  pressed;
    pressed = 1'b0;
    turns = 0;
    calm_out = 1'b0;
    @(posedge clk);
    while (!rst_n) @(posedge clk);
    forever begin
      if (!pressed && results_seen >= 300) begin
        pressed = 1'b1;
        n = 500;
      end else begin
        n = gap_len(calm_out);
      end
      if (n > 0) begin
        out_ready <= 1'b0;
        repeat (n) @(posedge clk);
      end
      out_ready <= 1'b1;
      @(posedge clk);
      if (out_valid) begin
        check_rsp(out_data);
        results_seen++;
      end
      turns++;
      if (turns % 256 == 0) calm_out = ($urandom_range(0, 3) == 0);
    end
  end

  initial begin
    req_t r;
    for (int i = 0; i < TOP_ENTRIES; i++) slot_owner[i] = 0;
    for (int i = 0; i < POOL * LEAF_ENTRIES; i++) leaf_pte[i] = '0;
    for (int i = 0; i < POOL; i++) begin
      table_busy[i] = 1'b0;
      table_fill[i] = 0;
    end
    space_on = 1'b0;
    mismatches = 0;
    items_sent = 0;
    results_seen = 0;
    calm_in = 1'b0;
    repeat (9) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    for (int i = 0; i < NPLAN; i++) begin
      if (i == OFF_ROWS) begin
        drain_results();
        write_space(32'h0000_0001);
      end
      put_item(PLAN[i].rq, PLAN[i].fixed, PLAN[i].want);
    end

    pick_working_set();
    repeat (500) put_item(rand_req(), 1'b0, R_CALC);

    // exhaust the table pool across many slots, then query and release every page
    for (int k = 0; k < 70; k++) begin
      r.req_type = REQ_MAP;
      r.virt_addr = {12'(12'h400 + k), 8'(k * 37), 12'($urandom)};
      r.frame_addr = $urandom | 32'h0000_1000;
      r.req_flags = 5'($urandom_range(0, 31));
      put_item(r, 1'b0, R_CALC);
    end
    for (int pass = 0; pass < 2; pass++) begin
      for (int k = 0; k < 70; k++) begin
        r.req_type = pass == 0 ? REQ_QUERY : REQ_UNMAP;
        r.virt_addr = {12'(12'h400 + k), 8'(k * 37), 12'($urandom)};
        r.frame_addr = $urandom;
        r.req_flags = 5'($urandom_range(0, 31));
        put_item(r, 1'b0, R_CALC);
      end
    end

    drain_results();
    write_space(32'hFFFF_FFFE);
    repeat (60) put_item(rand_req(), 1'b0, R_CALC);
    drain_results();
    write_space(32'hFFFF_FFFF);

    pick_working_set();
    repeat (450) put_item(rand_req(), 1'b0, R_CALC);

    drain_results();
    repeat (20) @(posedge clk);
    if (mismatches == 0 && pending_rsp.size() == 0) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end

endmodule

@@ files.f @@
rtl/tlpt_pkg.sv
rtl/tlpt_ram.sv
rtl/tlpt_free_pool.sv
rtl/two_level_page_table_engine.sv
verif/two_level_page_table_engine_test.sv
